### src/lomacc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package lomacc_pkg;

  localparam int unsigned NUM_COLS     = 27;
  localparam int unsigned NUM_TERMS    = 15;
  localparam int unsigned VALUE_W      = 24;
  localparam int unsigned DEF_COORD    = 16;
  localparam int unsigned DEF_FRAC     = 8;
  localparam int unsigned DEF_QDEPTH   = 2;

  // Item kinds carried in tuser
  typedef enum logic [1:0] {
    KIND_PIXEL = 2'd0,
    KIND_CLEAR = 2'd1,
    KIND_READ  = 2'd2
  } kind_e;

  // Register indexes
  localparam logic [2:0] CFG_OBJECT_LABEL = 3'd0;
  localparam logic [2:0] CFG_COLUMN_EN    = 3'd1;
  localparam logic [2:0] CFG_SHIFT_X      = 3'd2;
  localparam logic [2:0] CFG_SHIFT_Y      = 3'd3;
  localparam logic [2:0] CFG_MODE         = 3'd4;

  // Mode flag bits
  localparam int unsigned MODE_SHIFT = 0;
  localparam int unsigned MODE_VAL   = 1;
  localparam int unsigned MODE_CLUMP = 2;
  localparam int unsigned MODE_SKY   = 3;
  localparam int unsigned MODE_STD   = 4;
  localparam int unsigned MODE_VAR   = 5;
  localparam int unsigned MODE_BLANK = 6;

  // Sum columns
  localparam int unsigned COL_CNT    = 0;
  localparam int unsigned COL_SX     = 1;
  localparam int unsigned COL_SY     = 2;
  localparam int unsigned COL_SXX    = 3;
  localparam int unsigned COL_SYY    = 4;
  localparam int unsigned COL_SXY    = 5;
  localparam int unsigned COL_C_CNT  = 6;
  localparam int unsigned COL_C_SX   = 7;
  localparam int unsigned COL_C_SY   = 8;
  localparam int unsigned COL_V_CNT  = 9;
  localparam int unsigned COL_V_SUM  = 10;
  localparam int unsigned COL_CV_CNT = 11;
  localparam int unsigned COL_CV_SUM = 12;
  localparam int unsigned COL_P_CNT  = 13;
  localparam int unsigned COL_P_SUM  = 14;
  localparam int unsigned COL_P_SX   = 15;
  localparam int unsigned COL_P_SY   = 16;
  localparam int unsigned COL_P_SXX  = 17;
  localparam int unsigned COL_P_SYY  = 18;
  localparam int unsigned COL_P_SXY  = 19;
  localparam int unsigned COL_CP_CNT = 20;
  localparam int unsigned COL_CP_SUM = 21;
  localparam int unsigned COL_CP_SX  = 22;
  localparam int unsigned COL_CP_SY  = 23;
  localparam int unsigned COL_SKY    = 24;
  localparam int unsigned COL_VAR    = 25;
  localparam int unsigned COL_STD    = 26;
  localparam logic [4:0]  COL_CLUMP  = 5'd27;

  // Addend terms shared by the columns
  localparam logic [3:0] T_ONE  = 4'd0;
  localparam logic [3:0] T_X1   = 4'd1;
  localparam logic [3:0] T_Y1   = 4'd2;
  localparam logic [3:0] T_DXX  = 4'd3;
  localparam logic [3:0] T_DYY  = 4'd4;
  localparam logic [3:0] T_DXY  = 4'd5;
  localparam logic [3:0] T_V    = 4'd6;
  localparam logic [3:0] T_VX   = 4'd7;
  localparam logic [3:0] T_VY   = 4'd8;
  localparam logic [3:0] T_VDXX = 4'd9;
  localparam logic [3:0] T_VDYY = 4'd10;
  localparam logic [3:0] T_VDXY = 4'd11;
  localparam logic [3:0] T_SKY  = 4'd12;
  localparam logic [3:0] T_VAR  = 4'd13;
  localparam logic [3:0] T_SDAV = 4'd14;

  localparam logic [3:0] COL_TERM [NUM_COLS] = '{
    T_ONE, T_X1, T_Y1, T_DXX, T_DYY, T_DXY, T_ONE, T_X1, T_Y1,
    T_ONE, T_V, T_ONE, T_V, T_ONE, T_V, T_VX, T_VY, T_VDXX, T_VDYY,
    T_VDXY, T_ONE, T_V, T_VX, T_VY, T_SKY, T_VAR, T_SDAV};

  typedef struct packed {
    logic [30:0] object_label;
    logic [26:0] column_enable;
    logic [16:0] shift_x;
    logic [16:0] shift_y;
    logic [6:0]  mode;
  } cfg_t;

  // One classified item between front and back
  typedef struct packed {
    kind_e                          kind;
    logic [NUM_COLS-1:0]            mask;
    logic                           cupd;
    logic [30:0]                    clump;
    logic [NUM_TERMS-1:0][63:0]     terms;
  } ent_t;

  function automatic logic signed [63:0] sat_add64(logic signed [63:0] a,
                                                   logic signed [63:0] b);
    logic signed [63:0] s;
    s = a + b;
    if (a[63] == b[63] && s[63] != a[63]) begin
      s = a[63] ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
    end
    return s;
  endfunction

endpackage
`default_nettype wire

### src/lomacc_front.sv
`timescale 1ns / 1ps
`default_nettype none
module lomacc_front #(
  parameter int unsigned COORD_BITS      = lomacc_pkg::DEF_COORD,
  parameter int unsigned VALUE_FRAC_BITS = lomacc_pkg::DEF_FRAC,
  parameter int unsigned TDATA_W         = 176
) (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  lomacc_pkg::cfg_t        cfg_i,
  input  wire                     s_tvalid_i,
  output logic                    s_tready_o,
  input  wire  [1:0]              s_tuser_i,
  input  wire  [TDATA_W-1:0]      s_tdata_i,
  output logic                    push_o,
  output lomacc_pkg::ent_t        ent_o,
  input  wire                     full_i
);

  localparam int unsigned VW     = lomacc_pkg::VALUE_W;
  localparam int unsigned XW     = COORD_BITS + 1;
  localparam int unsigned DW     = ((XW > 17) ? XW : 17) + 1;
  localparam int unsigned PW     = (VW + 2 * DW + 1 > 65) ? VW + 2 * DW + 1 : 65;
  localparam int unsigned OFF_X  = 64;
  localparam int unsigned OFF_Y  = OFF_X + COORD_BITS;
  localparam int unsigned OFF_V  = OFF_Y + COORD_BITS;
  localparam int unsigned OFF_B  = OFF_V + VW;
  localparam int unsigned OFF_SK = OFF_B + 1;
  localparam int unsigned OFF_SD = OFF_SK + VW;
  localparam logic signed [PW-1:0] PMAX = PW'(64'sh7FFF_FFFF_FFFF_FFFF);
  localparam logic signed [PW-1:0] PMIN = PW'(64'sh8000_0000_0000_0000);

  logic adv;

  // Field decode
  logic [31:0]          f_plabel, f_clabel;
  logic [XW-1:0]        f_x1, f_y1;
  logic signed [VW-1:0] f_v, f_sky, f_sd;
  logic                 f_blank, f_match, f_oc, f_vo, f_pos;
  logic signed [DW-1:0] f_dx, f_dy;
  logic [lomacc_pkg::NUM_COLS-1:0] f_grp;
  lomacc_pkg::kind_e    f_kind;

  always_comb begin
    f_kind   = lomacc_pkg::kind_e'(s_tuser_i);
    f_plabel = s_tdata_i[31:0];
    f_clabel = s_tdata_i[63:32];
    f_x1     = XW'(s_tdata_i[OFF_X +: COORD_BITS]) + XW'(1);
    f_y1     = XW'(s_tdata_i[OFF_Y +: COORD_BITS]) + XW'(1);
    f_v      = s_tdata_i[OFF_V +: VW];
    f_blank  = s_tdata_i[OFF_B];
    f_sky    = s_tdata_i[OFF_SK +: VW];
    f_sd     = s_tdata_i[OFF_SD +: VW];
    f_dx     = $signed(DW'(f_x1)) - $signed(DW'(cfg_i.shift_x));
    f_dy     = $signed(DW'(f_y1)) - $signed(DW'(cfg_i.shift_y));
    f_match  = (f_kind == lomacc_pkg::KIND_PIXEL) && (f_plabel == {1'b0, cfg_i.object_label});
    f_oc     = cfg_i.mode[lomacc_pkg::MODE_CLUMP] && !f_clabel[31] && (|f_clabel);
    f_vo     = cfg_i.mode[lomacc_pkg::MODE_VAL]
               && !(cfg_i.mode[lomacc_pkg::MODE_BLANK] && f_blank);
    f_pos    = !f_v[VW-1] && (|f_v);

    // Which columns this pixel feeds
    f_grp = '0;
    f_grp[lomacc_pkg::COL_CNT]    = 1'b1;
    f_grp[lomacc_pkg::COL_SX]     = 1'b1;
    f_grp[lomacc_pkg::COL_SY]     = 1'b1;
    f_grp[lomacc_pkg::COL_SXX]    = cfg_i.mode[lomacc_pkg::MODE_SHIFT];
    f_grp[lomacc_pkg::COL_SYY]    = cfg_i.mode[lomacc_pkg::MODE_SHIFT];
    f_grp[lomacc_pkg::COL_SXY]    = cfg_i.mode[lomacc_pkg::MODE_SHIFT];
    f_grp[lomacc_pkg::COL_C_CNT]  = f_oc;
    f_grp[lomacc_pkg::COL_C_SX]   = f_oc;
    f_grp[lomacc_pkg::COL_C_SY]   = f_oc;
    f_grp[lomacc_pkg::COL_V_CNT]  = f_vo;
    f_grp[lomacc_pkg::COL_V_SUM]  = f_vo;
    f_grp[lomacc_pkg::COL_CV_CNT] = f_vo && f_oc;
    f_grp[lomacc_pkg::COL_CV_SUM] = f_vo && f_oc;
    f_grp[lomacc_pkg::COL_P_CNT]  = f_vo && f_pos;
    f_grp[lomacc_pkg::COL_P_SUM]  = f_vo && f_pos;
    f_grp[lomacc_pkg::COL_P_SX]   = f_vo && f_pos;
    f_grp[lomacc_pkg::COL_P_SY]   = f_vo && f_pos;
    f_grp[lomacc_pkg::COL_P_SXX]  = f_vo && f_pos && cfg_i.mode[lomacc_pkg::MODE_SHIFT];
    f_grp[lomacc_pkg::COL_P_SYY]  = f_vo && f_pos && cfg_i.mode[lomacc_pkg::MODE_SHIFT];
    f_grp[lomacc_pkg::COL_P_SXY]  = f_vo && f_pos && cfg_i.mode[lomacc_pkg::MODE_SHIFT];
    f_grp[lomacc_pkg::COL_CP_CNT] = f_vo && f_pos && f_oc;
    f_grp[lomacc_pkg::COL_CP_SUM] = f_vo && f_pos && f_oc;
    f_grp[lomacc_pkg::COL_CP_SX]  = f_vo && f_pos && f_oc;
    f_grp[lomacc_pkg::COL_CP_SY]  = f_vo && f_pos && f_oc;
    f_grp[lomacc_pkg::COL_SKY]    = cfg_i.mode[lomacc_pkg::MODE_SKY];
    f_grp[lomacc_pkg::COL_VAR]    = cfg_i.mode[lomacc_pkg::MODE_STD];
    f_grp[lomacc_pkg::COL_STD]    = cfg_i.mode[lomacc_pkg::MODE_STD];
    f_grp = f_grp & cfg_i.column_enable & {lomacc_pkg::NUM_COLS{f_match}};
  end

  // Stage registers
  logic                 a_vld_q, b_vld_q, c_vld_q;
  lomacc_pkg::kind_e    a_kind_q, b_kind_q, c_kind_q;
  logic [lomacc_pkg::NUM_COLS-1:0] a_mask_q, b_mask_q, c_mask_q;
  logic                 a_cupd_q, b_cupd_q, c_cupd_q;
  logic [30:0]          a_clump_q, b_clump_q, c_clump_q;
  logic [XW-1:0]        a_x1_q, a_y1_q, b_x1_q, b_y1_q, c_x1_q, c_y1_q;
  logic signed [DW-1:0] a_dx_q, a_dy_q;
  logic signed [VW-1:0] a_v_q, a_sky_q, a_sd_q, b_v_q, b_sky_q, c_v_q, c_sky_q;
  logic                 a_vo_q, a_vmode_q;
  logic signed [2*DW-1:0] b_dxx_q, b_dyy_q, b_dxy_q, c_dxx_q, c_dyy_q, c_dxy_q;
  logic signed [VW+XW:0]  b_vx_q, b_vy_q, c_vx_q, c_vy_q;
  logic signed [2*VW-1:0] b_var_q, c_var_q;
  logic signed [VW+1:0]   b_sdav_q, c_sdav_q;
  logic signed [VW+DW:0]  c_pl_xx_q, c_pl_yy_q, c_pl_xy_q;
  logic signed [VW+DW-1:0] c_ph_xx_q, c_ph_yy_q, c_ph_xy_q;

  // Stage B arithmetic
  logic signed [2*VW-1:0] b_sq;
  logic signed [VW:0]     b_av;
  always_comb begin
    b_sq = a_sd_q * a_sd_q;
    b_av = a_v_q[VW-1] ? -(VW+1)'(a_v_q) : (VW+1)'(a_v_q);
  end

  // Stall the whole pipe only while its tail cannot drain
  assign adv        = !(c_vld_q && full_i);
  assign s_tready_o = adv;
  assign push_o     = c_vld_q && !full_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
      c_vld_q <= 1'b0;
    end else if (adv) begin
      a_vld_q <= s_tvalid_i;
      b_vld_q <= a_vld_q;
      c_vld_q <= b_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a_kind_q  <= f_kind;
      a_mask_q  <= f_grp;
      a_cupd_q  <= f_match && f_oc;
      a_clump_q <= f_clabel[30:0];
      a_x1_q    <= f_x1;
      a_y1_q    <= f_y1;
      a_dx_q    <= f_dx;
      a_dy_q    <= f_dy;
      a_v_q     <= f_v;
      a_sky_q   <= f_sky;
      a_sd_q    <= f_sd;
      a_vo_q    <= f_vo;
      a_vmode_q <= cfg_i.mode[lomacc_pkg::MODE_VAR];

      b_kind_q  <= a_kind_q;
      b_mask_q  <= a_mask_q;
      b_cupd_q  <= a_cupd_q;
      b_clump_q <= a_clump_q;
      b_x1_q    <= a_x1_q;
      b_y1_q    <= a_y1_q;
      b_v_q     <= a_v_q;
      b_sky_q   <= a_sky_q;
      b_dxx_q   <= a_dx_q * a_dx_q;
      b_dyy_q   <= a_dy_q * a_dy_q;
      b_dxy_q   <= a_dx_q * a_dy_q;
      b_vx_q    <= a_v_q * $signed({1'b0, a_x1_q});
      b_vy_q    <= a_v_q * $signed({1'b0, a_y1_q});
      b_var_q   <= a_vmode_q ? (2*VW)'(a_sd_q) : (b_sq >>> VALUE_FRAC_BITS);
      b_sdav_q  <= (VW+2)'(a_sd_q) + (a_vo_q ? (VW+2)'(b_av) : (VW+2)'(0));

      c_kind_q  <= b_kind_q;
      c_mask_q  <= b_mask_q;
      c_cupd_q  <= b_cupd_q;
      c_clump_q <= b_clump_q;
      c_x1_q    <= b_x1_q;
      c_y1_q    <= b_y1_q;
      c_v_q     <= b_v_q;
      c_sky_q   <= b_sky_q;
      c_dxx_q   <= b_dxx_q;
      c_dyy_q   <= b_dyy_q;
      c_dxy_q   <= b_dxy_q;
      c_vx_q    <= b_vx_q;
      c_vy_q    <= b_vy_q;
      c_var_q   <= b_var_q;
      c_sdav_q  <= b_sdav_q;
      // Split v times second moment into low and high partial products
      c_pl_xx_q <= b_v_q * $signed({1'b0, b_dxx_q[DW-1:0]});
      c_pl_yy_q <= b_v_q * $signed({1'b0, b_dyy_q[DW-1:0]});
      c_pl_xy_q <= b_v_q * $signed({1'b0, b_dxy_q[DW-1:0]});
      c_ph_xx_q <= b_v_q * $signed(b_dxx_q[2*DW-1:DW]);
      c_ph_yy_q <= b_v_q * $signed(b_dyy_q[2*DW-1:DW]);
      c_ph_xy_q <= b_v_q * $signed(b_dxy_q[2*DW-1:DW]);
    end
  end

  // Combine partial products and clamp to 64 bits
  logic signed [PW-1:0] p_xx, p_yy, p_xy;
  logic signed [63:0]   s_xx, s_yy, s_xy;
  always_comb begin
    p_xx = (PW'(c_ph_xx_q) <<< DW) + PW'(c_pl_xx_q);
    p_yy = (PW'(c_ph_yy_q) <<< DW) + PW'(c_pl_yy_q);
    p_xy = (PW'(c_ph_xy_q) <<< DW) + PW'(c_pl_xy_q);
    s_xx = (p_xx > PMAX) ? 64'(PMAX) : (p_xx < PMIN) ? 64'(PMIN) : 64'(p_xx);
    s_yy = (p_yy > PMAX) ? 64'(PMAX) : (p_yy < PMIN) ? 64'(PMIN) : 64'(p_yy);
    s_xy = (p_xy > PMAX) ? 64'(PMAX) : (p_xy < PMIN) ? 64'(PMIN) : 64'(p_xy);

    ent_o.kind  = c_kind_q;
    ent_o.mask  = c_mask_q;
    ent_o.cupd  = c_cupd_q;
    ent_o.clump = c_clump_q;
    ent_o.terms = '0;
    ent_o.terms[lomacc_pkg::T_ONE]  = 64'd1;
    ent_o.terms[lomacc_pkg::T_X1]   = 64'(c_x1_q);
    ent_o.terms[lomacc_pkg::T_Y1]   = 64'(c_y1_q);
    ent_o.terms[lomacc_pkg::T_DXX]  = 64'(c_dxx_q);
    ent_o.terms[lomacc_pkg::T_DYY]  = 64'(c_dyy_q);
    ent_o.terms[lomacc_pkg::T_DXY]  = 64'(c_dxy_q);
    ent_o.terms[lomacc_pkg::T_V]    = 64'(c_v_q);
    ent_o.terms[lomacc_pkg::T_VX]   = 64'(c_vx_q);
    ent_o.terms[lomacc_pkg::T_VY]   = 64'(c_vy_q);
    ent_o.terms[lomacc_pkg::T_VDXX] = s_xx;
    ent_o.terms[lomacc_pkg::T_VDYY] = s_yy;
    ent_o.terms[lomacc_pkg::T_VDXY] = s_xy;
    ent_o.terms[lomacc_pkg::T_SKY]  = 64'(c_sky_q);
    ent_o.terms[lomacc_pkg::T_VAR]  = 64'(c_var_q);
    ent_o.terms[lomacc_pkg::T_SDAV] = 64'(c_sdav_q);
  end

endmodule
`default_nettype wire

### src/lomacc_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
module lomacc_fifo #(
  parameter int unsigned DEPTH = lomacc_pkg::DEF_QDEPTH
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               push_i,
  input  lomacc_pkg::ent_t  wdata_i,
  output logic              full_o,
  input  wire               pop_i,
  output logic              empty_o,
  output lomacc_pkg::ent_t  rdata_o
);

  // DEPTH must be a power of two so the pointers wrap on their own; the block does not enforce it
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  lomacc_pkg::ent_t mem_q [DEPTH];
  logic [AW-1:0] wr_q, rd_q;
  logic [CW-1:0] cnt_q;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + AW'(1);
      if (pop_i)  rd_q <= rd_q + AW'(1);
      if (push_i && !pop_i) cnt_q <= cnt_q + CW'(1);
      else if (pop_i && !push_i) cnt_q <= cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= wdata_i;
  end

endmodule
`default_nettype wire

### src/lomacc_back.sv
`timescale 1ns / 1ps
`default_nettype none
module lomacc_back (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               empty_i,
  input  lomacc_pkg::ent_t  ent_i,
  output logic              pop_o,
  output logic              m_tvalid_o,
  input  wire               m_tready_i,
  output logic [4:0]        m_tuser_o,
  output logic [63:0]       m_tdata_o,
  output logic              m_tlast_o
);

  typedef enum logic {
    ST_RUN,
    ST_READ
  } state_e;

  state_e             state_q;
  logic [4:0]         idx_q;
  logic signed [63:0] sums_q [lomacc_pkg::NUM_COLS];
  logic [30:0]        largest_q;
  logic               load;

  assign pop_o = (state_q == ST_RUN) && !empty_i;
  assign load  = (state_q == ST_READ) && (!m_tvalid_o || m_tready_i);

  // Readout sequencer and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_RUN;
      idx_q      <= '0;
      m_tvalid_o <= 1'b0;
      m_tuser_o  <= '0;
      m_tdata_o  <= '0;
      m_tlast_o  <= 1'b0;
    end else begin
      case (state_q)
        ST_RUN: begin
          if (m_tvalid_o && m_tready_i) m_tvalid_o <= 1'b0;
          if (pop_o && ent_i.kind == lomacc_pkg::KIND_READ) begin
            state_q <= ST_READ;
            idx_q   <= '0;
          end
        end
        ST_READ: begin
          if (load) begin
            m_tvalid_o <= 1'b1;
            m_tuser_o  <= idx_q;
            m_tdata_o  <= (idx_q == lomacc_pkg::COL_CLUMP) ? 64'(largest_q)
                                                            : sums_q[idx_q];
            m_tlast_o  <= (idx_q == lomacc_pkg::COL_CLUMP);
            if (idx_q == lomacc_pkg::COL_CLUMP) begin
              state_q <= ST_RUN;
              idx_q   <= '0;
            end else begin
              idx_q <= idx_q + 5'd1;
            end
          end
        end
        default: state_q <= ST_RUN;
      endcase
    end
  end

  // Accumulate, clear
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < lomacc_pkg::NUM_COLS; i++) sums_q[i] <= '0;
      largest_q <= '0;
    end else if (pop_o) begin
      case (ent_i.kind)
        lomacc_pkg::KIND_PIXEL: begin
          for (int i = 0; i < lomacc_pkg::NUM_COLS; i++) begin
            if (ent_i.mask[i]) begin
              sums_q[i] <= lomacc_pkg::sat_add64(sums_q[i],
                             $signed(ent_i.terms[lomacc_pkg::COL_TERM[i]]));
            end
          end
          if (ent_i.cupd && ent_i.clump > largest_q) largest_q <= ent_i.clump;
        end
        lomacc_pkg::KIND_CLEAR: begin
          for (int i = 0; i < lomacc_pkg::NUM_COLS; i++) sums_q[i] <= '0;
          largest_q <= '0;
        end
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

### src/labeled_object_moment_accumulator.sv
// Pixel and clear items: one per cycle unless a full queue stalls, applied to the sums on pop.
// Readout item: 28 beats, one per cycle while the sink takes them, the first one registered
// after the item is popped; the readout sequencer holds the work queue for those beats.
// Sustained throughput is one pixel per cycle while no readout run holds the work queue.
// Reset clears every sum, the largest clump label and the queue; registers take their defaults.
`timescale 1ns / 1ps
`default_nettype none
module labeled_object_moment_accumulator #(
  parameter int unsigned COORD_BITS      = lomacc_pkg::DEF_COORD,
  parameter int unsigned VALUE_FRAC_BITS = lomacc_pkg::DEF_FRAC,
  parameter int unsigned QUEUE_DEPTH     = lomacc_pkg::DEF_QDEPTH,
  localparam int unsigned TDATA_W        = ((137 + 2 * COORD_BITS + 7) / 8) * 8
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                cfg_we_i,
  input  wire  [2:0]         cfg_idx_i,
  input  wire  [30:0]        cfg_wdata_i,
  input  wire                s_tvalid_i,
  output logic               s_tready_o,
  // kind
  input  wire  [1:0]         s_tuser_i,
  // pixel_label, clump_label, x_coord, y_coord, value, value_blank, sky_value, sky_std
  input  wire  [TDATA_W-1:0] s_tdata_i,
  output logic               m_tvalid_o,
  input  wire                m_tready_i,
  // column_index
  output logic [4:0]         m_tuser_o,
  // column_value
  output logic [63:0]        m_tdata_o,
  output logic               m_tlast_o
);

  lomacc_pkg::cfg_t cfg_q;
  lomacc_pkg::ent_t push_ent, pop_ent;
  logic push, pop, full, empty;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.object_label  <= 31'd1;
      cfg_q.column_enable <= '0;
      cfg_q.shift_x       <= 17'd1;
      cfg_q.shift_y       <= 17'd1;
      cfg_q.mode          <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        lomacc_pkg::CFG_OBJECT_LABEL: cfg_q.object_label  <= cfg_wdata_i;
        lomacc_pkg::CFG_COLUMN_EN:    cfg_q.column_enable <= cfg_wdata_i[26:0];
        lomacc_pkg::CFG_SHIFT_X:      cfg_q.shift_x       <= cfg_wdata_i[16:0];
        lomacc_pkg::CFG_SHIFT_Y:      cfg_q.shift_y       <= cfg_wdata_i[16:0];
        lomacc_pkg::CFG_MODE:         cfg_q.mode          <= cfg_wdata_i[6:0];
        default: ;
      endcase
    end
  end

  lomacc_front #(
    .COORD_BITS      (COORD_BITS),
    .VALUE_FRAC_BITS (VALUE_FRAC_BITS),
    .TDATA_W         (TDATA_W)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .s_tuser_i  (s_tuser_i),
    .s_tdata_i  (s_tdata_i),
    .push_o     (push),
    .ent_o      (push_ent),
    .full_i     (full)
  );

  lomacc_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (push_ent),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .rdata_o (pop_ent)
  );

  lomacc_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .empty_i    (empty),
    .ent_i      (pop_ent),
    .pop_o      (pop),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .m_tuser_o  (m_tuser_o),
    .m_tdata_o  (m_tdata_o),
    .m_tlast_o  (m_tlast_o)
  );

  // The last beat of a readout carries the clump label slot
  a_last_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && m_tlast_o |-> m_tuser_o == lomacc_pkg::COL_CLUMP)
    else $error("readout run ends on the wrong column");

  // Readout beats follow back to back with rising column index
  a_run_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && m_tready_i && !m_tlast_o |=>
      m_tvalid_o && m_tuser_o == $past(m_tuser_o) + 5'd1)
    else $error("readout run broke or skipped a column");

  // Nothing is popped while a readout run is in progress
  a_no_pop_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && !m_tlast_o |-> !pop)
    else $error("queue popped during readout");

endmodule
`default_nettype wire

### tb/sv/lomacc_checker.sv
`timescale 1ns / 1ps
module lomacc_checker
  import lomacc_pkg::*;
#(
  parameter int unsigned DW = 176
) (
  input  wire           clk_i,
  input  wire           rst_ni,
  input  wire           cfg_we_i,
  input  wire  [2:0]    cfg_idx_i,
  input  wire  [30:0]   cfg_wdata_i,
  input  wire           s_tvalid_i,
  input  wire           s_tready_i,
  input  wire  [1:0]    s_tuser_i,
  input  wire  [DW-1:0] s_tdata_i,
  input  wire           m_tvalid_i,
  input  wire           m_tready_i,
  input  wire  [4:0]    m_tuser_i,
  input  wire  [63:0]   m_tdata_i,
  input  wire           m_tlast_i,
  output int            fail_count_o,
  output int            pending_o
);

  typedef struct {
    logic [4:0]         idx;
    logic signed [63:0] val;
    logic               last;
  } sum_beat_t;

  localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;

  // Shadow registers and sums
  logic [30:0]        obj_label;
  logic [26:0]        col_en;
  logic [16:0]        org_x, org_y;
  logic [6:0]         mode;
  logic signed [63:0] sums [NUM_COLS];
  logic [30:0]        top_clump;
  sum_beat_t          readout_q [$];

  function automatic logic signed [63:0] clamp_add(logic signed [63:0] a,
                                                   logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s > 65'sd0 && s[64] != s[63]) return S64_MAX;
    if (s[64] != s[63]) return S64_MIN;
    return s[63:0];
  endfunction

  function automatic logic signed [63:0] clamp_mul(logic signed [63:0] a,
                                                   logic signed [63:0] b);
    logic signed [127:0] p;
    p = 128'(a) * 128'(b);
    if (p > 128'(S64_MAX)) return S64_MAX;
    if (p < 128'(S64_MIN)) return S64_MIN;
    return p[63:0];
  endfunction

  task automatic add_col(int unsigned c, logic signed [63:0] v);
    if (col_en[c]) sums[c] = clamp_add(sums[c], v);
  endtask

  function automatic logic signed [63:0] sext24(logic [23:0] f);
    return {{40{f[23]}}, f};
  endfunction

  // Fold one pixel into the predicted sums
  task automatic fold_pixel(logic [DW-1:0] d);
    logic signed [31:0] pl, cl;
    logic signed [63:0] x1, y1, v, sky, sd, dx, dy, dxx, dyy, dxy, var_t, av;
    logic               blank, on_clump, val_ok;
    pl = d[31:0];
    cl = d[63:32];
    x1 = {48'd0, d[79:64]} + 64'sd1;
    y1 = {48'd0, d[95:80]} + 64'sd1;
    v = sext24(d[119:96]);
    blank = d[120];
    sky = sext24(d[144:121]);
    sd = sext24(d[168:145]);
    dx = x1 - {47'd0, org_x};
    dy = y1 - {47'd0, org_y};
    dxx = dx * dx;
    dyy = dy * dy;
    dxy = dx * dy;
    if (pl[31] || pl[30:0] != obj_label) return;
    on_clump = mode[MODE_CLUMP] && !cl[31] && cl != 32'sd0;
    val_ok = mode[MODE_VAL] && !(mode[MODE_BLANK] && blank);
    if (on_clump && cl[30:0] > top_clump) top_clump = cl[30:0];
    add_col(COL_CNT, 64'sd1);
    add_col(COL_SX, x1);
    add_col(COL_SY, y1);
    if (mode[MODE_SHIFT]) begin
      add_col(COL_SXX, dxx);
      add_col(COL_SYY, dyy);
      add_col(COL_SXY, dxy);
    end
    if (on_clump) begin
      add_col(COL_C_CNT, 64'sd1);
      add_col(COL_C_SX, x1);
      add_col(COL_C_SY, y1);
    end
    if (val_ok) begin
      add_col(COL_V_CNT, 64'sd1);
      add_col(COL_V_SUM, v);
      if (on_clump) begin
        add_col(COL_CV_CNT, 64'sd1);
        add_col(COL_CV_SUM, v);
      end
      if (v > 64'sd0) begin
        add_col(COL_P_CNT, 64'sd1);
        add_col(COL_P_SUM, v);
        add_col(COL_P_SX, v * x1);
        add_col(COL_P_SY, v * y1);
        if (mode[MODE_SHIFT]) begin
          add_col(COL_P_SXX, clamp_mul(v, dxx));
          add_col(COL_P_SYY, clamp_mul(v, dyy));
          add_col(COL_P_SXY, clamp_mul(v, dxy));
        end
        if (on_clump) begin
          add_col(COL_CP_CNT, 64'sd1);
          add_col(COL_CP_SUM, v);
          add_col(COL_CP_SX, v * x1);
          add_col(COL_CP_SY, v * y1);
        end
      end
    end
    if (mode[MODE_SKY]) add_col(COL_SKY, sky);
    if (mode[MODE_STD]) begin
      // squared std drops the extra fraction bits to stay Q15.8
      var_t = mode[MODE_VAR] ? sd : $signed(64'(sd * sd) >> DEF_FRAC);
      av = val_ok ? (v < 64'sd0 ? -v : v) : 64'sd0;
      add_col(COL_VAR, var_t);
      add_col(COL_STD, sd + av);
    end
  endtask

  task automatic zero_sums();
    for (int c = 0; c < NUM_COLS; c++) sums[c] = 64'sd0;
    top_clump = '0;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    sum_beat_t b;
    if (!rst_ni) begin
      obj_label = 31'd1;
      col_en = '0;
      org_x = 17'd1;
      org_y = 17'd1;
      mode = '0;
      zero_sums();
      readout_q.delete();
      fail_count_o = 0;
      pending_o = 0;
    end else begin
      // Compare each output beat with the oldest predicted sum
      if (m_tvalid_i && m_tready_i) begin
        if (readout_q.size() == 0) begin
          $error("unexpected beat: column_index %0d column_value %0d",
                 m_tuser_i, $signed(m_tdata_i));
          fail_count_o++;
        end else begin
          b = readout_q.pop_front();
          if (m_tuser_i !== b.idx) begin
            $error("column_index: expected %0d actual %0d", b.idx, m_tuser_i);
            fail_count_o++;
          end
          if (m_tdata_i !== b.val) begin
            $error("column_value (col %0d): expected %0d actual %0d",
                   b.idx, b.val, $signed(m_tdata_i));
            fail_count_o++;
          end
          if (m_tlast_i !== b.last) begin
            $error("last: expected %0d actual %0d", b.last, m_tlast_i);
            fail_count_o++;
          end
        end
      end
      // Track register writes
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_OBJECT_LABEL: obj_label = cfg_wdata_i;
          CFG_COLUMN_EN:    col_en = cfg_wdata_i[26:0];
          CFG_SHIFT_X:      org_x = cfg_wdata_i[16:0];
          CFG_SHIFT_Y:      org_y = cfg_wdata_i[16:0];
          CFG_MODE:         mode = cfg_wdata_i[6:0];
          default: ;
        endcase
      end
      // Apply each accepted input beat
      if (s_tvalid_i && s_tready_i) begin
        case (s_tuser_i)
          KIND_PIXEL: fold_pixel(s_tdata_i);
          KIND_CLEAR: zero_sums();
          KIND_READ: begin
            for (int c = 0; c < NUM_COLS; c++) begin
              b.idx = 5'(c);
              b.val = sums[c];
              b.last = 1'b0;
              readout_q.push_back(b);
            end
            b.idx = COL_CLUMP;
            b.val = {33'd0, top_clump};
            b.last = 1'b1;
            readout_q.push_back(b);
          end
          default: ;
        endcase
      end
      pending_o = readout_q.size();
    end
  end

endmodule

### tb/sv/tb_labeled_object_moment_accumulator.sv
`timescale 1ns / 1ps
module tb_labeled_object_moment_accumulator;
  import lomacc_pkg::*;

  localparam int unsigned DW = 176;
  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int unsigned STALL_LIMIT = 3000;
  localparam int unsigned PRESS_CYCLES = 400;

  logic          clk;
  logic          rst_n;
  logic          cfg_we;
  logic [2:0]    cfg_idx;
  logic [30:0]   cfg_wdata;
  logic          s_tvalid;
  logic          s_tready;
  logic [1:0]    s_tuser;
  logic [DW-1:0] s_tdata;
  logic          m_tvalid;
  logic          m_tready;
  logic [4:0]    m_tuser;
  logic [63:0]   m_tdata;
  logic          m_tlast;
  int            fail_count;
  int            pending;
  logic          press_req;
  logic [30:0]   obj;

  labeled_object_moment_accumulator u_top (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_wdata_i(cfg_wdata),
    .s_tvalid_i(s_tvalid), .s_tready_o(s_tready), .s_tuser_i(s_tuser),
    .s_tdata_i(s_tdata),
    .m_tvalid_o(m_tvalid), .m_tready_i(m_tready), .m_tuser_o(m_tuser),
    .m_tdata_o(m_tdata), .m_tlast_o(m_tlast)
  );

  lomacc_checker #(.DW(DW)) u_checker (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_wdata_i(cfg_wdata),
    .s_tvalid_i(s_tvalid), .s_tready_i(s_tready), .s_tuser_i(s_tuser),
    .s_tdata_i(s_tdata),
    .m_tvalid_i(m_tvalid), .m_tready_i(m_tready), .m_tuser_i(m_tuser),
    .m_tdata_i(m_tdata), .m_tlast_i(m_tlast),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    int idle_cycles;
    if (!rst_n || cfg_we || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // Sink: random back-pressure, plus one long hold-off on request
  initial begin
    int hold;
    bit pressed;
    int r;
    hold = 0;
    pressed = 0;
    m_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (press_req && !pressed) begin
        pressed = 1;
        hold = PRESS_CYCLES;
      end
      if (hold > 0) begin
        m_tready <= 1'b0;
        hold--;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 65) begin
          m_tready <= 1'b1;
        end else begin
          m_tready <= 1'b0;
          hold = (r < 95) ? $urandom_range(0, 3) : $urandom_range(10, 40);
        end
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [DW-1:0] pack_pixel(logic [31:0] pl, logic [31:0] cl,
                                               logic [15:0] x, logic [15:0] y,
                                               logic [23:0] v, logic blank,
                                               logic [23:0] sky, logic [23:0] sd);
    return DW'({sd, sky, blank, v, y, x, cl, pl});
  endfunction

  // Offer one beat and hold it until taken, then maybe idle
  task automatic put_item(logic [1:0] k, logic [DW-1:0] d, bit no_gap = 0);
    int gap;
    s_tvalid <= 1'b1;
    s_tuser <= k;
    s_tdata <= d;
    forever begin
      @(negedge clk);
      if (s_tready) break;
    end
    @(posedge clk);
    gap = no_gap ? 0 : pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drain all expected beats, then let the pipeline settle
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    forever begin
      @(negedge clk);
      if (pending == 0) break;
    end
    @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_regs(logic [30:0] o, logic [26:0] en, logic [16:0] sx,
                          logic [16:0] sy, logic [6:0] m);
    cfg_we <= 1'b1;
    cfg_idx <= CFG_OBJECT_LABEL; cfg_wdata <= o;
    @(posedge clk);
    cfg_idx <= CFG_COLUMN_EN; cfg_wdata <= 31'(en);
    @(posedge clk);
    cfg_idx <= CFG_SHIFT_X; cfg_wdata <= 31'(sx);
    @(posedge clk);
    cfg_idx <= CFG_SHIFT_Y; cfg_wdata <= 31'(sy);
    @(posedge clk);
    cfg_idx <= CFG_MODE; cfg_wdata <= 31'(m);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [DW-1:0] rand_pixel(logic [30:0] o);
    logic [31:0] pl, cl;
    logic [15:0] x, y;
    logic [23:0] v;
    int r;
    r = $urandom_range(0, 99);
    pl = (r < 82) ? {1'b0, o} : (r < 92) ? $urandom() : {1'b1, o};
    r = $urandom_range(0, 99);
    cl = (r < 45) ? $urandom_range(1, 200) : (r < 65) ? $urandom() :
         (r < 80) ? 32'd0 : {1'b1, 31'($urandom())};
    r = $urandom_range(0, 9);
    x = (r == 0) ? 16'd0 : (r == 1) ? 16'hFFFF : 16'($urandom());
    r = $urandom_range(0, 9);
    y = (r == 0) ? 16'd0 : (r == 1) ? 16'hFFFF : 16'($urandom());
    r = $urandom_range(0, 9);
    v = (r < 3) ? 24'($signed($urandom_range(0, 2000)) - 1000) : 24'($urandom());
    return pack_pixel(pl, cl, x, y, v, 1'($urandom()), 24'($urandom()),
                      24'($urandom()));
  endfunction

  initial begin
    logic [26:0] en;
    logic [16:0] sx, sy;
    int r;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_wdata = '0;
    s_tvalid = 1'b0;
    s_tuser = '0;
    s_tdata = '0;
    press_req = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset sums, coordinate and value extremes, clumps, blanks
    put_item(KIND_READ, '0);
    wait_idle();
    obj = 31'd5;
    set_regs(obj, 27'h7FF_FFFF, 17'd1, 17'd1, 7'h7F);
    put_item(KIND_PIXEL, pack_pixel(32'd5, 32'd3, 16'd0, 16'd0, 24'h7FFFFF, 1'b0,
                                    24'h7FFFFF, 24'h7FFFFF));
    put_item(KIND_PIXEL, pack_pixel(32'd5, 32'h7FFFFFFF, 16'hFFFF, 16'hFFFF, 24'h800000,
                                    1'b0, 24'h800000, 24'h800000));
    put_item(KIND_PIXEL, pack_pixel(32'd5, 32'h80000000, 16'd7, 16'd9, 24'h000100, 1'b1,
                                    24'h000010, 24'hFFFF00));
    put_item(KIND_PIXEL, pack_pixel(32'd5, 32'd0, 16'd1, 16'd1, 24'd0, 1'b0, 24'd0, 24'd0));
    put_item(KIND_PIXEL, pack_pixel(32'd6, 32'd9, 16'd2, 16'd2, 24'd50, 1'b0, 24'd1, 24'd1));
    put_item(KIND_PIXEL, pack_pixel(32'h80000005, 32'd9, 16'd2, 16'd2, 24'd50, 1'b0,
                                    24'd1, 24'd1));
    put_item(KIND_UNUSED, pack_pixel(32'd5, 32'd9, 16'd2, 16'd2, 24'd50, 1'b0, 24'd1, 24'd1));
    put_item(KIND_READ, '0);
    put_item(KIND_CLEAR, '0);
    put_item(KIND_READ, '0);
    wait_idle();
    set_regs(obj, 27'h7FF_FFFF, 17'h10000, 17'h10000, 7'h3F);
    put_item(KIND_PIXEL, pack_pixel(32'd5, 32'd4, 16'd0, 16'hFFFF, 24'h7FFFFF, 1'b1,
                                    24'h000001, 24'h800000));
    put_item(KIND_PIXEL, pack_pixel(32'd5, 32'd2, 16'hFFFF, 16'd0, 24'hFFFFFF, 1'b0,
                                    24'hFFFFFF, 24'h7FFFFF));
    put_item(KIND_READ, '0);
    wait_idle();

    // Random phases, each under its own register setting
    for (int ph = 0; ph < 12; ph++) begin
      r = $urandom_range(0, 3);
      en = (r == 0) ? 27'h7FF_FFFF : (r == 1) ? 27'd0 : 27'($urandom());
      sx = ($urandom_range(0, 3) == 0) ? 17'h10000 : 17'($urandom_range(1, 65536));
      sy = ($urandom_range(0, 3) == 0) ? 17'd1 : 17'($urandom_range(1, 65536));
      obj = 31'($urandom_range(1, 32'h7FFF_FFFF));
      if (ph == 0) set_regs(31'h7FFF_FFFF, 27'd0, 17'h10000, 17'h10000, 7'd0);
      else if (ph == 1) set_regs(31'd1, 27'h7FF_FFFF, 17'd1, 17'd1, 7'h7F);
      else set_regs(obj, (ph < 4) ? 27'h7FF_FFFF : en, sx, sy, 7'($urandom()));
      obj = (ph == 0) ? 31'h7FFF_FFFF : (ph == 1) ? 31'd1 : obj;
      put_item(KIND_CLEAR, '0);
      if (ph == 6) begin
        // Block fills while the sink holds off
        put_item(KIND_READ, '0, 1);
        press_req <= 1'b1;
        for (int i = 0; i < 20; i++) put_item(KIND_PIXEL, rand_pixel(obj), 1);
      end
      for (int i = 0; i < 24; i++) begin
        r = $urandom_range(0, 99);
        if (r < 9) put_item(KIND_READ, '0);
        else if (r < 11) put_item(KIND_CLEAR, '0);
        else if (r < 12) put_item(KIND_UNUSED, rand_pixel(obj));
        else put_item(KIND_PIXEL, rand_pixel(obj));
      end
      put_item(KIND_READ, '0);
      wait_idle();
    end

    repeat (30) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### sim.f
src/lomacc_pkg.sv
src/lomacc_front.sv
src/lomacc_fifo.sv
src/lomacc_back.sv
src/labeled_object_moment_accumulator.sv
tb/sv/lomacc_checker.sv
tb/sv/tb_labeled_object_moment_accumulator.sv
